/* hw/rtl/wabs_pkg.sv */
// ----------------------------------------------------------------------------
// wabs_pkg: shared types and constants
// Field widths, register codes and reset values for the windowed average
// baseline subtractor.
// ----------------------------------------------------------------------------
package wabs_pkg;

    localparam int DATA_W     = 32;  // Q16.16 sample and result
    localparam int CHAN_W     = 3;   // channel selector
    localparam int WIN_W      = 14;  // window bound registers
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [WIN_W-1:0] SIGNAL_FIRST_RST     = 14'd0;
    localparam logic [WIN_W-1:0] SIGNAL_LAST_RST      = 14'd0;
    localparam logic [WIN_W-1:0] BACKGROUND_FIRST_RST = 14'd1600;
    localparam logic [WIN_W-1:0] BACKGROUND_LAST_RST  = 14'd1650;

    localparam logic [DATA_W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] Q_MIN = 32'h8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIGNAL_FIRST     = 8'd0,
        CFG_SIGNAL_LAST      = 8'd1,
        CFG_BACKGROUND_FIRST = 8'd2,
        CFG_BACKGROUND_LAST  = 8'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [WIN_W-1:0] signal_first;
        logic [WIN_W-1:0] signal_last;
        logic [WIN_W-1:0] background_first;
        logic [WIN_W-1:0] background_last;
    } cfg_regs_t;

endpackage

/* hw/rtl/windowed_average_baseline_subtract.sv */
// ----------------------------------------------------------------------------
// windowed_average_baseline_subtract: boxcar mean with baseline removal
// Sums the samples of a waveform inside a signal window and a background
// window and, at the last sample, reports signal mean minus background mean.
// ----------------------------------------------------------------------------
//
//  channel | direction | tdata / data          | tuser (low bit up)          | end
//  --------+-----------+-----------------------+-----------------------------+------
//  s_      | in        | sample_value  [31:0]  | channel_id [2:0]            | tlast = last_sample
//  m_      | out       | mean_difference[31:0] | result_channel[2:0],        | none
//          |           |                       | windows_valid [3]           |
//  cfg_    | in        | cfg_data[13:0] value  | cfg_index = register number | none
//
//  Samples enter one per cycle while the job queue has room; the front adds
//  each into the window sums in the cycle it is accepted.
//  In the back, the one-bit-per-cycle shared divider (ACC_W = 47 at the
//  default MAX_SAMPLES) forms both means of each waveform in turn when both
//  windows are non-empty; a two-entry job queue lets the next waveforms
//  stream in meanwhile.
//  s_tready drops only while the job queue is full; m_tready low holds the
//  result register, then the back, then the queue.
//  Reset is synchronous, active low; it restores the window registers to their
//  defaults and clears the sums, the queue and the result valid flag.
//
module windowed_average_baseline_subtract import wabs_pkg::*; #(
    parameter int MAX_SAMPLES = 16384,
    parameter int CHANNELS    = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // sample stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [DATA_W-1:0]     s_tdata,   // sample_value[31:0]
    input  logic [CHAN_W-1:0]     s_tuser,   // channel_id[2:0]
    input  logic                  s_tlast,   // last_sample
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [DATA_W-1:0]     m_tdata,   // mean_difference[31:0]
    output logic [CHAN_W:0]       m_tuser,   // result_channel[2:0], windows_valid[3]
    // register writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // position counter saturates at MAX_SAMPLES, so it must hold that value
    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    // sums of up to MAX_SAMPLES signed samples
    localparam int ACC_W = DATA_W + $clog2(MAX_SAMPLES) + 1;
    localparam int JOB_W = CHAN_W + 2 * (ACC_W + CNT_W);

    cfg_regs_t        cfg_reg;
    logic             q_push, q_full, q_valid, q_pop;
    logic [JOB_W-1:0] q_din, q_dout;

    // window registers: always ready, unknown indexes drop the write
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.signal_first     <= SIGNAL_FIRST_RST;
            cfg_reg.signal_last      <= SIGNAL_LAST_RST;
            cfg_reg.background_first <= BACKGROUND_FIRST_RST;
            cfg_reg.background_last  <= BACKGROUND_LAST_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SIGNAL_FIRST:     cfg_reg.signal_first     <= cfg_data[WIN_W-1:0];
                CFG_SIGNAL_LAST:      cfg_reg.signal_last      <= cfg_data[WIN_W-1:0];
                CFG_BACKGROUND_FIRST: cfg_reg.background_first <= cfg_data[WIN_W-1:0];
                CFG_BACKGROUND_LAST:  cfg_reg.background_last  <= cfg_data[WIN_W-1:0];
                default: ;
            endcase
        end
    end

    // front: count positions, accumulate windows, hand off one job per waveform
    wabs_front #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .CHANNELS    (CHANNELS),
        .CNT_W       (CNT_W),
        .ACC_W       (ACC_W),
        .JOB_W       (JOB_W)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_din)
    );

    // queue: decouple sample intake from the slow divide
    wabs_queue #(
        .WIDTH (JOB_W),
        .DEPTH (2)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (q_din),
        .full    (q_full),
        .valid   (q_valid),
        .pop     (q_pop),
        .dout    (q_dout)
    );

    // back: divide, subtract, saturate, present the result
    wabs_back #(
        .CNT_W (CNT_W),
        .ACC_W (ACC_W),
        .JOB_W (JOB_W)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_dout   (q_dout),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

/* hw/rtl/wabs_front.sv */
// ----------------------------------------------------------------------------
// wabs_front: sample intake and window accumulation
// Counts sample positions, sums and tallies both windows, and pushes one job
// per waveform into the job queue.
// ----------------------------------------------------------------------------
module wabs_front import wabs_pkg::*; #(
    parameter int MAX_SAMPLES = 16384,
    parameter int CHANNELS    = 8,
    parameter int CNT_W       = 15,
    parameter int ACC_W       = 47,
    parameter int JOB_W       = CHAN_W + 2 * (ACC_W + CNT_W)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cfg_regs_t         cfg,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,
    input  logic [CHAN_W-1:0] s_tuser,
    input  logic              s_tlast,
    input  logic              q_full,
    output logic              q_push,
    output logic [JOB_W-1:0]  q_data
);

    localparam int CMP_W = (CNT_W > WIN_W) ? CNT_W : WIN_W;

    logic [CNT_W-1:0]        pos_reg, pos_next;
    logic signed [ACC_W-1:0] sig_acc_reg, sig_acc_next;
    logic signed [ACC_W-1:0] bg_acc_reg, bg_acc_next;
    logic [CNT_W-1:0]        sig_cnt_reg, sig_cnt_next;
    logic [CNT_W-1:0]        bg_cnt_reg, bg_cnt_next;
    logic signed [ACC_W-1:0] sample_ext;
    logic [CMP_W-1:0]        pos_c;
    logic                    take, counting, in_sig, in_bg;

    assign s_tready   = !q_full;
    assign take       = s_tvalid && !q_full && (32'(s_tuser) < CHANNELS);
    assign counting   = pos_reg < CNT_W'(MAX_SAMPLES);
    assign pos_c      = CMP_W'(pos_reg);
    assign sample_ext = ACC_W'(signed'(s_tdata));

    assign in_sig = counting && (pos_c >= CMP_W'(cfg.signal_first))
                             && (pos_c <= CMP_W'(cfg.signal_last));
    assign in_bg  = counting && (pos_c >= CMP_W'(cfg.background_first))
                             && (pos_c <= CMP_W'(cfg.background_last));

    always_comb begin
        pos_next     = counting ? pos_reg + CNT_W'(1) : pos_reg;
        sig_acc_next = in_sig ? sig_acc_reg + sample_ext : sig_acc_reg;
        sig_cnt_next = in_sig ? sig_cnt_reg + CNT_W'(1) : sig_cnt_reg;
        bg_acc_next  = in_bg ? bg_acc_reg + sample_ext : bg_acc_reg;
        bg_cnt_next  = in_bg ? bg_cnt_reg + CNT_W'(1) : bg_cnt_reg;
    end

    assign q_push = take && s_tlast;
    assign q_data = {s_tuser, sig_acc_next, sig_cnt_next, bg_acc_next, bg_cnt_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            sig_acc_reg <= '0;
            sig_cnt_reg <= '0;
            bg_acc_reg  <= '0;
            bg_cnt_reg  <= '0;
        end else if (take) begin
            if (s_tlast) begin
                // waveform handed off: start the next one from scratch
                pos_reg     <= '0;
                sig_acc_reg <= '0;
                sig_cnt_reg <= '0;
                bg_acc_reg  <= '0;
                bg_cnt_reg  <= '0;
            end else begin
                pos_reg     <= pos_next;
                sig_acc_reg <= sig_acc_next;
                sig_cnt_reg <= sig_cnt_next;
                bg_acc_reg  <= bg_acc_next;
                bg_cnt_reg  <= bg_cnt_next;
            end
        end
    end

endmodule

/* hw/rtl/wabs_queue.sv */
// ----------------------------------------------------------------------------
// wabs_queue: job queue
// Small register FIFO between the accumulation front and the divide back.
// ----------------------------------------------------------------------------
module wabs_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    output logic             full,
    output logic             valid,
    input  logic             pop,
    output logic [WIDTH-1:0] dout
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    function automatic logic [PTR_W-1:0] ptr_adv(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign full  = count_reg == CNT_W'(DEPTH);
    assign valid = count_reg != '0;
    assign dout  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ptr_adv(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= ptr_adv(rd_ptr_reg);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

/* hw/rtl/wabs_div.sv */
// ----------------------------------------------------------------------------
// wabs_div: iterative signed divider
// Restoring division of a signed sum by a nonzero count, one quotient bit per
// cycle, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module wabs_div #(
    parameter int NUM_W = 47,
    parameter int DEN_W = 15
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [NUM_W-1:0] num,
    input  logic [DEN_W-1:0]        den,
    output logic                    busy,
    output logic                    done,
    output logic signed [NUM_W-1:0] quot
);

    localparam int STEP_W = $clog2(NUM_W);

    logic              busy_reg, done_reg, neg_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DEN_W-1:0]  rem_reg, den_reg;
    logic [NUM_W-1:0]  q_reg;
    logic [DEN_W:0]    trial, trial_sub;
    logic              ge;

    assign trial     = {rem_reg, q_reg[NUM_W-1]};
    assign ge        = trial >= {1'b0, den_reg};
    assign trial_sub = trial - {1'b0, den_reg};

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = signed'(neg_reg ? -q_reg : q_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && step_reg == STEP_W'(NUM_W - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            // divide magnitudes, restore the sign at the end
            neg_reg  <= num[NUM_W-1];
            q_reg    <= num[NUM_W-1] ? -num : num;
            den_reg  <= den;
            rem_reg  <= '0;
            step_reg <= '0;
        end else if (busy_reg) begin
            rem_reg  <= ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
            q_reg    <= {q_reg[NUM_W-2:0], ge};
            step_reg <= step_reg + STEP_W'(1);
        end
    end

endmodule

/* hw/rtl/wabs_back.sv */
// ----------------------------------------------------------------------------
// wabs_back: mean and difference sequencer
// Takes one job at a time, divides both sums by their tallies when both are
// nonzero (else both means read as zero), subtracts the means with saturation
// and loads the result register.
module wabs_back import wabs_pkg::*; #(
    parameter int CNT_W = 15,
    parameter int ACC_W = 47,
    parameter int JOB_W = CHAN_W + 2 * (ACC_W + CNT_W)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    output logic              q_pop,
    input  logic [JOB_W-1:0]  q_dout,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,
    output logic [CHAN_W:0]   m_tuser
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV_SIG,
        ST_DIV_BG,
        ST_EMIT
    } state_t;

    state_t                  state_reg;
    logic [CHAN_W-1:0]       job_chan, chan_reg;
    logic signed [ACC_W-1:0] job_sig_acc, job_bg_acc, bg_acc_reg;
    logic [CNT_W-1:0]        job_sig_cnt, job_bg_cnt, bg_cnt_reg;
    logic signed [ACC_W-1:0] sig_mean_reg, bg_mean_reg;
    logic                    valid_reg, job_ok;
    logic                    m_tvalid_reg;
    logic [DATA_W-1:0]       m_tdata_reg;
    logic [CHAN_W:0]         m_tuser_reg;
    logic                    emit_load;

    logic                    div_start, div_busy, div_done;
    logic signed [ACC_W-1:0] div_num, div_quot;
    logic [CNT_W-1:0]        div_den;

    logic signed [ACC_W:0]   diff;
    logic [ACC_W-DATA_W+1:0] diff_hi;
    logic [DATA_W-1:0]       diff_sat;

    assign {job_chan, job_sig_acc, job_sig_cnt, job_bg_acc, job_bg_cnt} = q_dout;
    assign job_ok = (job_sig_cnt != '0) && (job_bg_cnt != '0);

    assign q_pop     = (state_reg == ST_IDLE) && q_valid;
    assign div_start = (q_pop && job_ok) || ((state_reg == ST_DIV_SIG) && div_done);
    assign div_num   = (state_reg == ST_IDLE) ? job_sig_acc : bg_acc_reg;
    assign div_den   = (state_reg == ST_IDLE) ? job_sig_cnt : bg_cnt_reg;

    // result register free or being drained this cycle
    assign emit_load = (state_reg == ST_EMIT) && (!m_tvalid_reg || m_tready);

    wabs_div #(
        .NUM_W (ACC_W),
        .DEN_W (CNT_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .done    (div_done),
        .quot    (div_quot)
    );

    // clamp to the Q16.16 range when the upper bits are not all sign
    assign diff     = (ACC_W + 1)'(sig_mean_reg) - (ACC_W + 1)'(bg_mean_reg);
    assign diff_hi  = diff[ACC_W:DATA_W-1];
    assign diff_sat = ((&diff_hi) || !(|diff_hi)) ? diff[DATA_W-1:0]
                    : (diff[ACC_W] ? Q_MIN : Q_MAX);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (emit_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        chan_reg   <= job_chan;
                        bg_acc_reg <= job_bg_acc;
                        bg_cnt_reg <= job_bg_cnt;
                        valid_reg  <= job_ok;
                        if (job_ok) begin
                            state_reg <= ST_DIV_SIG;
                        end else begin
                            // empty window: both means read as zero
                            sig_mean_reg <= '0;
                            bg_mean_reg  <= '0;
                            state_reg    <= ST_EMIT;
                        end
                    end
                end
                ST_DIV_SIG: begin
                    if (div_done) begin
                        sig_mean_reg <= div_quot;
                        state_reg    <= ST_DIV_BG;
                    end
                end
                ST_DIV_BG: begin
                    if (div_done) begin
                        bg_mean_reg <= div_quot;
                        state_reg   <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (emit_load) begin
                        m_tdata_reg  <= diff_sat;
                        m_tuser_reg  <= {valid_reg, chan_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider restarted mid-division");

    a_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV_SIG || state_reg == ST_DIV_BG))
        else $error("divider finished outside a divide step");

    a_pop_leaves: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> state_reg != ST_IDLE)
        else $error("job popped without being worked on");

    a_zero_invalid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tuser_reg[CHAN_W]) |-> m_tdata_reg == '0)
        else $error("empty-window result carries nonzero data");

endmodule

/* sim/wabs_result_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wabs_result_checker: result predictor and comparator
// Watches the sample, result and register channels, folds each accepted
// sample into its own copy of the window sums, and checks every result
// against the oldest predicted one.
// ----------------------------------------------------------------------------
module wabs_result_checker import wabs_pkg::*; #(
    parameter int MAX_SAMPLES = 16384,
    parameter int CHANNELS    = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [DATA_W-1:0]     s_tdata,
    input  logic [CHAN_W-1:0]     s_tuser,
    input  logic                  s_tlast,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [DATA_W-1:0]     m_tdata,
    input  logic [CHAN_W:0]       m_tuser,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    pending_results,
    output int                    results_checked,
    output int                    empty_results,
    output int                    clamped_results,
    output int                    samples_taken
);

    localparam longint Q_HI = longint'(signed'(Q_MAX));
    localparam longint Q_LO = longint'(signed'(Q_MIN));

    typedef struct {
        logic [CHAN_W-1:0] chan;
        logic [DATA_W-1:0] diff;
        logic              valid;
    } mean_result_t;

    mean_result_t expected_means[$];

    cfg_regs_t windows;
    int        position;
    longint    signal_sum;
    longint    backgr_sum;
    int        signal_count;
    int        backgr_count;
    int        fail_count;
    int        checked;
    int        empties;
    int        clamps;
    int        taken;

    task automatic flag_mismatch(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("mismatch: %s", msg);
    endtask

    task automatic clear_waveform();
        position     = 0;
        signal_sum   = 0;
        backgr_sum   = 0;
        signal_count = 0;
        backgr_count = 0;
    endtask

    task automatic apply_write(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] word);
        case (idx)
            CFG_SIGNAL_FIRST:     windows.signal_first     = word[WIN_W-1:0];
            CFG_SIGNAL_LAST:      windows.signal_last      = word[WIN_W-1:0];
            CFG_BACKGROUND_FIRST: windows.background_first = word[WIN_W-1:0];
            CFG_BACKGROUND_LAST:  windows.background_last  = word[WIN_W-1:0];
            default: ;
        endcase
    endtask

    // Fold one sample into the window sums; on the last one, predict the result.
    task automatic accumulate_sample(input logic [CHAN_W-1:0] chan,
                                     input logic [DATA_W-1:0] value,
                                     input logic last);
        longint       sample;
        longint       diff;
        mean_result_t want;
        sample = longint'(signed'(value));
        if (int'(chan) >= CHANNELS) return;
        taken++;
        if (position < MAX_SAMPLES) begin
            if (position >= int'(windows.signal_first) &&
                position <= int'(windows.signal_last)) begin
                signal_sum += sample;
                signal_count++;
            end
            if (position >= int'(windows.background_first) &&
                position <= int'(windows.background_last)) begin
                backgr_sum += sample;
                backgr_count++;
            end
            position++;
        end
        if (!last) return;
        diff = 0;
        want.valid = (signal_count > 0) && (backgr_count > 0);
        if (want.valid) begin
            // signed division truncates toward zero
            diff = signal_sum / longint'(signal_count) - backgr_sum / longint'(backgr_count);
            if (diff > Q_HI) begin
                diff = Q_HI;
                clamps++;
            end else if (diff < Q_LO) begin
                diff = Q_LO;
                clamps++;
            end
        end else begin
            empties++;
        end
        want.chan = chan;
        want.diff = diff[DATA_W-1:0];
        expected_means.push_back(want);
        clear_waveform();
    endtask

    task automatic check_result();
        mean_result_t want;
        mean_result_t got;
        got.chan  = m_tuser[CHAN_W-1:0];
        got.valid = m_tuser[CHAN_W];
        got.diff  = m_tdata;
        if (expected_means.size() == 0) begin
            flag_mismatch($sformatf("result ch %0d diff %h valid %0d with none expected",
                                    got.chan, got.diff, got.valid));
            return;
        end
        want = expected_means.pop_front();
        checked++;
        if (got.chan !== want.chan)
            flag_mismatch($sformatf("result_channel expected %0d got %0d", want.chan, got.chan));
        if (got.diff !== want.diff)
            flag_mismatch($sformatf("mean_difference expected %h got %h (ch %0d)",
                                    want.diff, got.diff, want.chan));
        if (got.valid !== want.valid)
            flag_mismatch($sformatf("windows_valid expected %0d got %0d (ch %0d)",
                                    want.valid, got.valid, want.chan));
    endtask

    initial begin
        fail_count = 0;
        checked    = 0;
        empties    = 0;
        clamps     = 0;
        taken      = 0;
        windows    = '0;
        clear_waveform();
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            windows.signal_first     = SIGNAL_FIRST_RST;
            windows.signal_last      = SIGNAL_LAST_RST;
            windows.background_first = BACKGROUND_FIRST_RST;
            windows.background_last  = BACKGROUND_LAST_RST;
            clear_waveform();
            expected_means.delete();
        end else begin
            if (m_tvalid && m_tready) check_result();
            if (cfg_valid && cfg_ready) apply_write(cfg_index, cfg_data);
            if (s_tvalid && s_tready) accumulate_sample(s_tuser, s_tdata, s_tlast);
        end
        pending_results <= expected_means.size();
        mismatches      <= fail_count;
        results_checked <= checked;
        empty_results   <= empties;
        clamped_results <= clamps;
        samples_taken   <= taken;
    end

endmodule

/* sim/windowed_average_baseline_subtract_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_average_baseline_subtract_test: stimulus and verdict
// Streams directed and random waveforms through the baseline subtractor under
// several window settings and idle patterns; the checker beside the block
// predicts every mean difference and counts mismatches.
// ----------------------------------------------------------------------------
module windowed_average_baseline_subtract_test import wabs_pkg::*; ();

    localparam int MAX_SAMPLES   = 16384;
    localparam int CHANNELS      = 8;
    localparam int RESET_CYCLES  = 7;
    // two means through the serial divider per result, two jobs queued
    localparam int SETTLE_CYCLES = 400;
    localparam int HOLD_CYCLES   = 600;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int PHASE_ITEMS   = 110;
    // a longer waveform than the random phases produce
    localparam int LONG_WAVE     = 64;
    localparam int WIN_TOP       = (1 << WIN_W) - 1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED =
        CFG_IDX_W'(int'(CFG_BACKGROUND_LAST) + 1);

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [DATA_W-1:0]     s_tdata   = '0;   // sample_value[31:0]
    logic [CHAN_W-1:0]     s_tuser   = '0;   // channel_id[2:0]
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [DATA_W-1:0]     m_tdata;          // mean_difference[31:0]
    logic [CHAN_W:0]       m_tuser;          // result_channel[2:0], windows_valid[3]
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int mismatches;
    int pending_results;
    int results_checked;
    int empty_results;
    int clamped_results;
    int samples_taken;

    // idle knobs, in percent of cycles
    int send_gap_pct   = 0;
    int recv_stall_pct = 0;

    // long output hold-off: flip hold_toggle to start one
    logic hold_toggle = 1'b0;
    logic hold_seen   = 1'b0;
    int   hold_left   = 0;
    int   cycles      = 0;

    always #6 aclk = ~aclk;

    windowed_average_baseline_subtract #(
        .MAX_SAMPLES(MAX_SAMPLES),
        .CHANNELS   (CHANNELS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    wabs_result_checker #(
        .MAX_SAMPLES(MAX_SAMPLES),
        .CHANNELS   (CHANNELS)
    ) checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatches     (mismatches),
        .pending_results(pending_results),
        .results_checked(results_checked),
        .empty_results  (empty_results),
        .clamped_results(clamped_results),
        .samples_taken  (samples_taken)
    );

    // Receiver: random stalls, or a counted hold-off when one is requested.
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (hold_toggle != hold_seen) begin
            hold_seen <= hold_toggle;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: end the run if the block stops making progress.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_results);
            $display("status: fail");
            $finish;
        end
    end

    // Offer one item, with random gaps ahead of it; return on the accepting edge.
    task automatic send_sample(input logic [CHAN_W-1:0] chan,
                               input logic [DATA_W-1:0] value,
                               input logic last);
        while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= chan;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Mostly wide random values, with the extremes and small values mixed in.
    function automatic logic [DATA_W-1:0] pick_sample();
        case ($urandom_range(7))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2, 3:    return DATA_W'(int'($urandom_range(2000)) - 1000);
            default: return DATA_W'($urandom);
        endcase
    endfunction

    // One waveform of random samples; mostly one channel, sometimes mixed.
    task automatic send_waveform(input int len);
        logic [CHAN_W-1:0] chan;
        bit                mixed;
        chan  = CHAN_W'($urandom);
        mixed = ($urandom_range(7) == 0);
        for (int i = 0; i < len; i++) begin
            if (mixed) chan = CHAN_W'($urandom);
            send_sample(chan, pick_sample(), i == len - 1);
        end
    endtask

    // Write one register; the bits above the window width carry random junk.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        logic [CFG_DATA_W-1:0] word;
        word             = CFG_DATA_W'($urandom);
        word[WIN_W-1:0]  = WIN_W'(value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= word;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // Load all four window bounds, plus one write to an unused index.
    task automatic set_windows(input int sig_first, input int sig_last,
                               input int bg_first, input int bg_last);
        write_reg(CFG_SIGNAL_FIRST, sig_first);
        write_reg(CFG_SIGNAL_LAST, sig_last);
        write_reg(CFG_FIRST_UNUSED +
                  CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1 - CFG_FIRST_UNUSED)),
                  int'($urandom));
        write_reg(CFG_BACKGROUND_FIRST, bg_first);
        write_reg(CFG_BACKGROUND_LAST, bg_last);
        cfg_valid <= 1'b0;
    endtask

    // Stop sending, wait for every predicted result, then let the divider go quiet.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_results != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Random waveforms until the item budget of the phase is spent.
    task automatic random_phase(input int gap_pct, input int stall_pct);
        int sent;
        int len;
        send_gap_pct   = gap_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < PHASE_ITEMS) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(60, 25) : $urandom_range(24, 1);
            send_waveform(len);
            sent += len;
        end
        settle();
    endtask

    initial begin
        int sf;
        int bf;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset windows: background starts at 1600, so a short waveform has none.
        send_sample(3'd4, 32'h0002_0000, 1'b1);
        settle();

        // Signal at position 0, background at position 1.
        set_windows(0, 0, 1, 1);
        send_sample(3'd7, Q_MAX, 1'b0);        // difference clamps high
        send_sample(3'd7, Q_MIN, 1'b1);
        send_sample(3'd0, Q_MIN, 1'b0);        // difference clamps low
        send_sample(3'd0, Q_MAX, 1'b1);
        send_sample(3'd3, 32'h0001_8000, 1'b1); // background window never reached
        send_sample(3'd2, 32'h0005_0000, 1'b0); // mixed channels, result takes the last
        send_sample(3'd5, 32'hFFFF_FFFD, 1'b1);
        settle();

        // Negative signal mean of -1/3 must truncate to zero, not round down.
        set_windows(0, 2, 3, 3);
        send_sample(3'd1, 32'hFFFF_FFFF, 1'b0);
        send_sample(3'd1, 32'hFFFF_FFFF, 1'b0);
        send_sample(3'd1, 32'h0000_0001, 1'b0);
        send_sample(3'd1, 32'h0000_0007, 1'b1);
        settle();

        // Inverted signal window, full-range background.
        set_windows(3, 1, 0, WIN_TOP);
        send_sample(3'd6, 32'h1234_5678, 1'b0);
        send_sample(3'd6, 32'h8765_4321, 1'b0);
        send_sample(3'd6, 32'h0000_0000, 1'b1);
        settle();

        // Inverted background window at the register extremes.
        set_windows(0, WIN_TOP, WIN_TOP, 0);
        send_sample(3'd2, 32'h7FFF_0000, 1'b0);
        send_sample(3'd2, 32'h8000_FFFF, 1'b1);
        settle();

        // One longer waveform: signal spans every position, background only the last.
        set_windows(0, WIN_TOP, LONG_WAVE - 1, LONG_WAVE - 1);
        send_waveform(LONG_WAVE);
        settle();

        // Phase 1: no idling; hold the output long enough to back up the input.
        set_windows(2, 9, 12, 20);
        hold_toggle <= ~hold_toggle;
        for (int i = 0; i < 12; i++) send_waveform(2);
        settle();
        random_phase(0, 0);

        // Phase 2: sender idles most cycles, random windows that may overlap.
        sf = $urandom_range(8);
        bf = $urandom_range(20);
        set_windows(sf, sf + $urandom_range(12), bf, bf + $urandom_range(15));
        random_phase(73, 0);

        // Phase 3: receiver stalls most cycles; background covers the signal.
        set_windows(0, 0, 0, 30);
        random_phase(0, 73);

        // Phase 4: both sides idle now and then; windows may come out inverted.
        sf = $urandom_range(10);
        bf = $urandom_range(10);
        set_windows(sf, sf + $urandom_range(14) - 2, bf, bf + $urandom_range(20) - 3);
        random_phase(24, 24);

        recv_stall_pct = 0;
        $display("checked %0d results from %0d samples: %0d with an empty window, %0d clamped",
                 results_checked, samples_taken, empty_results, clamped_results);
        $display("windows at reset, inverted and at full range, a %0d-sample waveform, %0d-cycle hold-off",
                 LONG_WAVE, HOLD_CYCLES);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("status: fail");
        end
        $finish;
    end

endmodule
